>>> rtl/rou_pkg.sv
// rou_pkg: shared types, codes and helpers of the rank-one update core
// used by rou_cfg and rank_one_matrix_update_core; no dependencies
package rou_pkg;

  localparam int MaxRowsDef = 256;
  localparam int MaxColsDef = 256;

  localparam int DataW   = 32;
  localparam int IndexW  = 8;
  localparam int CountW  = 9;
  localparam int CfgIdxW = 4;
  localparam int FracW   = 16;
  localparam int ProdW   = 2 * DataW;
  localparam int ShiftW  = ProdW - FracW;
  localparam int SumW    = ShiftW + 1;

  typedef enum logic [1:0] {
    CmdLoadX  = 2'd0,
    CmdLoadY  = 2'd1,
    CmdUpdate = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] CfgAlphaGain   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgBetaGain    = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgRowCount    = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 4'd3;

  localparam logic [DataW-1:0]  AlphaReset = 32'h0001_0000;
  localparam logic [DataW-1:0]  BetaReset  = 32'h0001_0000;
  localparam logic [CountW-1:0] CountReset = 9'd256;

  typedef struct packed {
    logic [DataW-1:0]  alpha_gain;
    logic [DataW-1:0]  beta_gain;
    logic [CountW-1:0] row_count;
    logic [CountW-1:0] column_count;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             clipped;
  } sat_t;

  // clip a signed sum to the 32-bit range
  function automatic sat_t sat32(input logic [SumW-1:0] v);
    sat_t r;
    if (v[SumW-1:DataW-1] == {(SumW-DataW+1){v[SumW-1]}}) begin
      r.value   = v[DataW-1:0];
      r.clipped = 1'b0;
    end else begin
      r.value   = v[SumW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      r.clipped = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/rou_cfg.sv
// rou_cfg: configuration registers of the rank-one update core
// depends on rou_pkg
module rou_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rou_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rou_pkg::DataW-1:0]   cfg_data_i,
  output rou_pkg::cfg_t               cfg_o
);

  rou_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_gain   <= rou_pkg::AlphaReset;
      cfg_q.beta_gain    <= rou_pkg::BetaReset;
      cfg_q.row_count    <= rou_pkg::CountReset;
      cfg_q.column_count <= rou_pkg::CountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rou_pkg::CfgAlphaGain:   cfg_q.alpha_gain   <= cfg_data_i;
        rou_pkg::CfgBetaGain:    cfg_q.beta_gain    <= cfg_data_i;
        rou_pkg::CfgRowCount:    cfg_q.row_count    <= cfg_data_i[rou_pkg::CountW-1:0];
        rou_pkg::CfgColumnCount: cfg_q.column_count <= cfg_data_i[rou_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rou_store.sv
// rou_store: single-port-write, single-port-read memory with registered read
// no dependencies; used for the x and scaled y vectors
module rou_store #(
  parameter int Depth = 256,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/rank_one_matrix_update_core.sv
// rank_one_matrix_update_core: top level, five-stage pipeline of A = beta*A + alpha*x*y^T
// depends on rou_pkg, rou_cfg, rou_store
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | cmd_i, row_index_i, col_index_i, operand_value_i
//  out     | output    | out_valid_o/out_stall_i | updated_value_o, status_o, saturated_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one request per cycle while the output is not stalled; an update passes the stages below in order to the output
// stage 1 gain multiply, stage 2 store write and read, stage 3 x*y multiply, stage 4 sum
// and clip, then the output register
// reset clears valid bits and sets configuration to its reset values; store contents are undefined until loaded
// the whole pipe holds while the output request is stalled, so nothing is lost or repeated
module rank_one_matrix_update_core #(
  parameter int MAX_ROWS = rou_pkg::MaxRowsDef,
  parameter int MAX_COLS = rou_pkg::MaxColsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [rou_pkg::IndexW-1:0]  row_index_i,
  input  logic [rou_pkg::IndexW-1:0]  col_index_i,
  input  logic [rou_pkg::DataW-1:0]   operand_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rou_pkg::DataW-1:0]   updated_value_o,
  output logic                        status_o,
  output logic                        saturated_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rou_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rou_pkg::DataW-1:0]   cfg_data_i
);

  localparam int RowAw = $clog2(MAX_ROWS);
  localparam int ColAw = $clog2(MAX_COLS);
  localparam int DW    = rou_pkg::DataW;
  localparam int IW    = rou_pkg::IndexW;

  typedef struct packed {
    logic load_x;
    logic load_y;
    logic update;
    logic err;
    logic x_ok;
    logic y_ok;
  } ctl_t;

  rou_pkg::cfg_t cfg;

  rou_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic adv;
  logic accept;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign adv        = !in_stall_o;
  assign accept     = in_valid_i && adv;

  // stage 1: decoded request
  ctl_t          s1_ctl_d, s1_ctl_q;
  logic [IW-1:0] s1_row_q, s1_col_q;
  logic [DW-1:0] s1_val_q;
  logic [31:0]   row_w, col_w;

  assign row_w = 32'(row_index_i);
  assign col_w = 32'(col_index_i);

  always_comb begin
    s1_ctl_d        = '0;
    s1_ctl_d.load_x = accept && (cmd_i == rou_pkg::CmdLoadX);
    s1_ctl_d.load_y = accept && (cmd_i == rou_pkg::CmdLoadY);
    s1_ctl_d.update = accept && (cmd_i == rou_pkg::CmdUpdate);
    s1_ctl_d.x_ok   = row_w < 32'(MAX_ROWS);
    s1_ctl_d.y_ok   = row_w < 32'(MAX_COLS);
    s1_ctl_d.err    = ({1'b0, row_index_i} >= cfg.row_count) ||
                      ({1'b0, col_index_i} >= cfg.column_count) ||
                      (row_w >= 32'(MAX_ROWS)) || (col_w >= 32'(MAX_COLS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (adv) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q <= row_index_i;
      s1_col_q <= col_index_i;
      s1_val_q <= operand_value_i;
    end
  end

  // gain multiply: alpha for y loads, beta for updates
  logic [DW-1:0]               s1_gain;
  logic [rou_pkg::ProdW-1:0]   s1_prod;

  assign s1_gain = s1_ctl_q.load_y ? cfg.alpha_gain : cfg.beta_gain;
  assign s1_prod = rou_pkg::ProdW'($signed(s1_gain) * $signed(s1_val_q));

  // stage 2: store access
  ctl_t                      s2_ctl_q;
  logic [IW-1:0]             s2_row_q, s2_col_q;
  logic [DW-1:0]             s2_val_q;
  logic [rou_pkg::ProdW-1:0] s2_prod_q;
  logic [rou_pkg::ShiftW-1:0] s2_shift;
  rou_pkg::sat_t             s2_ysat;
  logic [31:0]               s2_row_w, s2_col_w;
  logic [RowAw-1:0]          x_waddr, x_raddr;
  logic [ColAw-1:0]          y_waddr, y_raddr;
  logic                      x_we, y_we, st_re;
  logic [DW-1:0]             x_rdata, y_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (adv) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_val_q  <= s1_val_q;
      s2_prod_q <= s1_prod;
    end
  end

  assign s2_shift = s2_prod_q[rou_pkg::ProdW-1:rou_pkg::FracW];
  assign s2_ysat  = rou_pkg::sat32({s2_shift[rou_pkg::ShiftW-1], s2_shift});
  assign s2_row_w = 32'(s2_row_q);
  assign s2_col_w = 32'(s2_col_q);
  assign x_waddr  = s2_row_w[RowAw-1:0];
  assign y_waddr  = s2_row_w[ColAw-1:0];
  assign x_raddr  = s2_row_w[RowAw-1:0];
  assign y_raddr  = s2_col_w[ColAw-1:0];

  // writes land before the next request reaches this stage, so no forwarding is needed
  assign x_we  = adv && s2_ctl_q.load_x && s2_ctl_q.x_ok;
  assign y_we  = adv && s2_ctl_q.load_y && s2_ctl_q.y_ok;
  assign st_re = adv && s2_ctl_q.update;

  rou_store #(.Depth(MAX_ROWS), .Width(DW)) u_x_store (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (s2_val_q),
    .re_i    (st_re),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  rou_store #(.Depth(MAX_COLS), .Width(DW)) u_y_store (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (y_waddr),
    .wdata_i (s2_ysat.value),
    .re_i    (st_re),
    .raddr_i (y_raddr),
    .rdata_o (y_rdata)
  );

  // stage 3: x*y multiply
  logic                       s3_upd_q, s3_err_q;
  logic [rou_pkg::ShiftW-1:0] s3_bt_q;
  logic [rou_pkg::ProdW-1:0]  s3_xy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_upd_q <= 1'b0;
    end else if (adv) begin
      s3_upd_q <= s2_ctl_q.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_err_q <= s2_ctl_q.err;
      s3_bt_q  <= s2_shift;
    end
  end

  assign s3_xy = rou_pkg::ProdW'($signed(x_rdata) * $signed(y_rdata));

  // stage 4: sum and clip
  logic                       s4_upd_q, s4_err_q;
  logic [rou_pkg::ShiftW-1:0] s4_bt_q;
  logic [rou_pkg::ProdW-1:0]  s4_xy_q;
  logic [rou_pkg::SumW-1:0]   s4_sum;
  rou_pkg::sat_t              s4_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_upd_q <= 1'b0;
    end else if (adv) begin
      s4_upd_q <= s3_upd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_err_q <= s3_err_q;
      s4_bt_q  <= s3_bt_q;
      s4_xy_q  <= s3_xy;
    end
  end

  assign s4_sum = {s4_bt_q[rou_pkg::ShiftW-1], s4_bt_q} +
                  {s4_xy_q[rou_pkg::ProdW-1], s4_xy_q[rou_pkg::ProdW-1:rou_pkg::FracW]};
  assign s4_sat = rou_pkg::sat32(s4_sum);

  // output register
  logic          out_valid_q;
  logic [DW-1:0] out_value_q;
  logic          out_status_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_upd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= s4_err_q;
      out_value_q  <= s4_err_q ? '0 : s4_sat.value;
      out_sat_q    <= s4_err_q ? 1'b0 : s4_sat.clipped;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign updated_value_o = out_value_q;
  assign status_o        = out_status_q;
  assign saturated_o     = out_sat_q;

  a_stall_only_from_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("input stalled without a waiting result");

  a_error_result_clean: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (updated_value_o == '0 && !saturated_o)
  ) else $error("error result carries data");

  a_saturated_at_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (updated_value_o == 32'h7fff_ffff || updated_value_o == 32'h8000_0000)
  ) else $error("saturated result not at a limit");

  a_update_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i == rou_pkg::CmdUpdate && !out_valid_o) ##1
      (!in_stall_o) [*4] |=> out_valid_o
  ) else $error("update lost in the pipeline");

endmodule
